>>> hdl/cvs_pkg.sv
// ----------------------------------------------------------------------------
// cvs_pkg
// Shared types and constants for the scaled valid-region 2D convolution.
// ----------------------------------------------------------------------------
package cvs_pkg;

    localparam int unsigned REG_IMAGE_SIZE  = 0;
    localparam int unsigned REG_KERNEL_SIZE = 1;

    localparam int unsigned PIX_W = 8;
    localparam int unsigned COEF_W = 8;
    localparam int unsigned RES_W = 16;
    localparam int unsigned ACC_W = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_acc;   // zero the accumulator
        logic mac;         // accumulate one product at the current tap
        logic div_start;   // load the divider with the accumulator
        logic div_step;    // one restoring division step
        logic load_out;    // move the quotient into the output register
    } t_dp_cmd;

endpackage

>>> hdl/cvs_datapath.sv
// ----------------------------------------------------------------------------
// cvs_datapath
// Kernel and line memories, multiply-accumulate and serial divider.
// ----------------------------------------------------------------------------
module cvs_datapath #(
    parameter int unsigned MAX_IMAGE  = 32,
    parameter int unsigned MAX_KERNEL = 5,
    parameter int unsigned KW = $clog2(MAX_KERNEL * MAX_KERNEL),
    parameter int unsigned LW = $clog2(MAX_KERNEL * MAX_IMAGE)
) (
    input  logic                          i_clk,
    input  cvs_pkg::t_dp_cmd              i_cmd,
    input  logic                          i_kwr,
    input  logic [KW-1:0]                 i_kwaddr,
    input  logic signed [cvs_pkg::COEF_W-1:0] i_kwdata,
    input  logic                          i_lwr,
    input  logic [LW-1:0]                 i_lwaddr,
    input  logic [cvs_pkg::PIX_W-1:0]     i_lwdata,
    input  logic [KW-1:0]                 i_krdaddr,
    input  logic [LW-1:0]                 i_lrdaddr,
    input  logic [5:0]                    i_area,
    output logic signed [cvs_pkg::RES_W-1:0] o_quot
);
    localparam int unsigned KD = MAX_KERNEL * MAX_KERNEL;
    localparam int unsigned LD = MAX_KERNEL * MAX_IMAGE;
    localparam int unsigned A = cvs_pkg::ACC_W;

    logic signed [cvs_pkg::COEF_W-1:0] r_kmem [KD];
    logic [cvs_pkg::PIX_W-1:0]         r_lmem [LD];
    logic signed [cvs_pkg::COEF_W-1:0] r_kq;
    logic [cvs_pkg::PIX_W-1:0]         r_lq;
    logic signed [A-1:0]               r_acc;
    logic [A-1:0]                      r_rem;
    logic [A-1:0]                      r_qb;
    logic                              r_neg;
    logic [A-1:0]                      n_rem;
    logic signed [16:0]                w_prod;

    always_ff @(posedge i_clk) begin
        if (i_kwr) r_kmem[i_kwaddr] <= i_kwdata;
        if (i_lwr) r_lmem[i_lwaddr] <= i_lwdata;
        r_kq <= r_kmem[i_krdaddr];
        r_lq <= r_lmem[i_lrdaddr];
    end

    assign w_prod = $signed({1'b0, r_lq}) * r_kq;
    assign n_rem  = {r_rem[A-2:0], r_qb[A-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_acc) r_acc <= '0;
        else if (i_cmd.mac) r_acc <= r_acc + A'(w_prod);
        if (i_cmd.div_start) begin
            r_neg <= r_acc[A-1];
            r_qb  <= r_acc[A-1] ? A'(-r_acc) : A'(r_acc);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            if (n_rem >= A'(i_area)) begin
                r_rem <= n_rem - A'(i_area);
                r_qb  <= {r_qb[A-2:0], 1'b1};
            end else begin
                r_rem <= n_rem;
                r_qb  <= {r_qb[A-2:0], 1'b0};
            end
        end
        if (i_cmd.load_out)
            o_quot <= r_neg ? cvs_pkg::RES_W'(-r_qb) : cvs_pkg::RES_W'(r_qb);
    end
endmodule

>>> hdl/cvs_ctrl.sv
// ----------------------------------------------------------------------------
// cvs_ctrl
// Frame counters, load indexes and the sequencer for one window.
// ----------------------------------------------------------------------------
module cvs_ctrl #(
    parameter int unsigned MAX_IMAGE  = 32,
    parameter int unsigned MAX_KERNEL = 5,
    parameter int unsigned IW = $clog2(MAX_IMAGE),
    parameter int unsigned KW = $clog2(MAX_KERNEL * MAX_KERNEL),
    parameter int unsigned LW = $clog2(MAX_KERNEL * MAX_IMAGE),
    parameter int unsigned RW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic [0:0]                i_cfg_index,
    input  logic                      i_cfg_known,
    input  logic [5:0]                i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_action,
    input  logic                      i_ostall,
    output logic                      o_valid,
    output logic                      o_last,
    output cvs_pkg::t_dp_cmd          o_cmd,
    output logic                      o_kwr,
    output logic [KW-1:0]             o_kwaddr,
    output logic                      o_lwr,
    output logic [LW-1:0]             o_lwaddr,
    output logic [KW-1:0]             o_krdaddr,
    output logic [LW-1:0]             o_lrdaddr,
    output logic [5:0]                o_area
);
    typedef enum logic [2:0] {S_IDLE, S_MAC, S_TAIL, S_DIV, S_OUT} t_state;
    localparam int unsigned CW = IW + 1;
    localparam int unsigned A = cvs_pkg::ACC_W;

    t_state        r_state;
    logic [6:0]    r_img;
    logic [2:0]    r_ksz;
    logic [CW-1:0] r_row, r_col;
    logic [RW-1:0] r_slot;
    logic [RW:0]   r_kr, r_kc;
    logic [RW:0]   r_a, r_b;
    logic [RW-1:0] r_ts;
    logic [CW-1:0] r_ec;
    logic          r_elast;
    logic [1:0]    r_pipe;
    logic [5:0]    r_dcnt;

    logic [CW-1:0] w_n, w_r, w_c;
    logic [RW-1:0] w_slot;
    logic [3:0]    w_k;
    logic [RW:0]   w_kr, w_kc;
    logic          w_emit, w_accept;
    logic [CW-1:0] w_tc;

    assign w_n = (r_img == 7'd0) ? CW'(1) :
                 (r_img > 7'(MAX_IMAGE)) ? CW'(MAX_IMAGE) : CW'(r_img);
    assign w_k = (r_ksz == 3'd0) ? 4'd1 :
                 ({1'b0, r_ksz} > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : {1'b0, r_ksz};
    assign o_area = 6'(w_k * w_k);
    assign w_r = (r_row >= w_n) ? '0 : r_row;
    assign w_c = (r_col >= w_n) ? '0 : r_col;
    assign w_slot = (r_row >= w_n) ? '0 : r_slot;
    // The kernel load position walks row and column of the kernel directly.
    assign w_kr = (r_kr >= (RW+1)'(w_k)) ? '0 : r_kr;
    assign w_kc = (r_kr >= (RW+1)'(w_k) || r_kc >= (RW+1)'(w_k)) ? '0 : r_kc;
    assign w_emit = (w_r + CW'(1) >= CW'(w_k)) && (w_c + CW'(1) >= CW'(w_k));
    assign o_stall = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;

    assign o_kwr = w_accept && !i_action;
    assign o_kwaddr = KW'(w_kr * (RW+1)'(MAX_KERNEL) + w_kc);
    assign o_lwr = w_accept && i_action;
    assign o_lwaddr = LW'(LW'(w_slot) * LW'(MAX_IMAGE) + LW'(w_c));
    assign w_tc = r_ec - CW'(r_b);
    assign o_krdaddr = KW'(r_a * (RW+1)'(MAX_KERNEL) + r_b);
    assign o_lrdaddr = LW'(LW'(r_ts) * LW'(MAX_IMAGE) + LW'(w_tc));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_img <= 7'd8; r_ksz <= 3'd3;
            r_row <= '0; r_col <= '0; r_slot <= '0; r_kr <= '0; r_kc <= '0;
            o_valid <= 1'b0; o_cmd <= '0; r_pipe <= '0;
        end else begin
            o_cmd <= '0;
            r_pipe <= {r_pipe[0], 1'b0};
            if (o_valid && !i_ostall) o_valid <= 1'b0;
            if (i_cfg_valid && i_cfg_known) begin
                if (i_cfg_index == 1'(cvs_pkg::REG_IMAGE_SIZE)) r_img <= {1'b0, i_cfg_data};
                else r_ksz <= i_cfg_data[2:0];
                r_row <= '0; r_col <= '0; r_slot <= '0; r_kr <= '0; r_kc <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_kwr) begin
                        if (w_kc + 1'b1 >= (RW+1)'(w_k)) begin
                            r_kc <= '0;
                            r_kr <= (w_kr + 1'b1 >= (RW+1)'(w_k)) ? '0 : w_kr + 1'b1;
                        end else r_kc <= w_kc + 1'b1;
                    end else if (o_lwr) begin
                        r_ec <= w_c;
                        r_elast <= (w_r == w_n - 1'b1) && (w_c == w_n - 1'b1);
                        if (w_c + 1'b1 >= w_n) begin
                            r_col <= '0;
                            if (w_r + 1'b1 >= w_n) begin
                                r_row <= '0;
                                r_slot <= '0;
                            end else begin
                                r_row <= w_r + 1'b1;
                                r_slot <= (w_slot == RW'(MAX_KERNEL - 1)) ? '0
                                                                          : w_slot + 1'b1;
                            end
                        end else r_col <= w_c + 1'b1;
                        if (w_emit) begin
                            r_a <= '0; r_b <= '0;
                            r_ts <= w_slot;
                            o_cmd.clear_acc <= 1'b1;
                            r_state <= S_MAC;
                        end
                    end
                end
                S_MAC: begin
                    // One tap address per cycle; the registered read lands in the following
                    // cycle, together with the accumulate command.
                    r_pipe[0] <= 1'b1;
                    o_cmd.mac <= 1'b1;
                    if (r_b + 1'b1 >= (RW+1)'(w_k)) begin
                        r_b <= '0;
                        if (r_a + 1'b1 >= (RW+1)'(w_k)) r_state <= S_TAIL;
                        else begin
                            r_a <= r_a + 1'b1;
                            r_ts <= (r_ts == '0) ? RW'(MAX_KERNEL - 1) : r_ts - 1'b1;
                        end
                    end else r_b <= r_b + 1'b1;
                end
                S_TAIL: begin
                    if (r_pipe == 2'b00) begin
                        o_cmd.div_start <= 1'b1;
                        r_dcnt <= 6'(A);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_dcnt == 6'd0) begin
                        // The quotient may only land once the output beat is free.
                        if (!o_valid || !i_ostall) begin
                            o_cmd.load_out <= 1'b1;
                            r_state <= S_OUT;
                        end
                    end else begin
                        o_cmd.div_step <= 1'b1;
                        r_dcnt <= r_dcnt - 1'b1;
                    end
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    o_last <= r_elast;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> hdl/conv2d_valid_scaled_core.sv
// ----------------------------------------------------------------------------
// conv2d_valid_scaled_core
// Valid-region 2D convolution with a true-flipped kernel, scaled by 1/(K*K).
// ----------------------------------------------------------------------------
// A coefficient beat, or a pixel beat that completes no window, is written
// to memory without stalling the input. For a pixel beat that completes a
// window, the window is summed one tap per cycle through the single
// multiplier and the memory read ports, then the sum is divided by K*K in a
// 32-step restoring divider. While that runs, the input is stalled. A finished
// result waits in the output register without blocking the input; only when a
// second division finishes while the first result still waits does the block
// hold at the end of the division until the output beat leaves.
// Configuration writes clear the frame position and the kernel load index.
// Coefficients read before they are written give undefined results.
module conv2d_valid_scaled_core #(
    parameter int unsigned MAX_IMAGE  = 32,
    parameter int unsigned MAX_KERNEL = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic signed [7:0] i_coefficient,
    input  logic [7:0]  i_pixel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [15:0] o_result,
    output logic        o_last_of_frame
);
    localparam int unsigned KW = $clog2(MAX_KERNEL * MAX_KERNEL);
    localparam int unsigned LW = $clog2(MAX_KERNEL * MAX_IMAGE);

    cvs_pkg::t_dp_cmd w_cmd;
    logic w_kwr, w_lwr;
    logic [KW-1:0] w_kwaddr, w_krdaddr;
    logic [LW-1:0] w_lwaddr, w_lrdaddr;
    logic [5:0] w_area;
    logic w_known;

    // Writes are always taken; an index beyond the list is dropped.
    assign o_cfg_ready = 1'b1;
    assign w_known = (i_cfg_index == 8'(cvs_pkg::REG_IMAGE_SIZE)) ||
                     (i_cfg_index == 8'(cvs_pkg::REG_KERNEL_SIZE));

    cvs_ctrl #(.MAX_IMAGE(MAX_IMAGE), .MAX_KERNEL(MAX_KERNEL)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_index(i_cfg_index[0:0]), .i_cfg_known(w_known),
        .i_cfg_data(i_cfg_data[5:0]),
        .i_valid, .o_stall, .i_action,
        .i_ostall(i_stall), .o_valid, .o_last(o_last_of_frame),
        .o_cmd(w_cmd), .o_kwr(w_kwr), .o_kwaddr(w_kwaddr),
        .o_lwr(w_lwr), .o_lwaddr(w_lwaddr),
        .o_krdaddr(w_krdaddr), .o_lrdaddr(w_lrdaddr), .o_area(w_area)
    );

    cvs_datapath #(.MAX_IMAGE(MAX_IMAGE), .MAX_KERNEL(MAX_KERNEL)) u_dp (
        .i_clk, .i_cmd(w_cmd),
        .i_kwr(w_kwr), .i_kwaddr(w_kwaddr), .i_kwdata(i_coefficient),
        .i_lwr(w_lwr), .i_lwaddr(w_lwaddr), .i_lwdata(i_pixel),
        .i_krdaddr(w_krdaddr), .i_lrdaddr(w_lrdaddr), .i_area(w_area),
        .o_quot(o_result)
    );
endmodule
